FILE: rtl/ftpf_pkg.sv
`timescale 1ns / 1ps
package ftpf_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 12;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int TRI_LAT      = 4;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] MODE_ADD       = 2'd0;
  localparam logic [1:0] MODE_SUBTRACT  = 2'd1;
  localparam logic [1:0] MODE_OVERWRITE = 2'd2;

  localparam logic REG_COMBINE_MODE = 1'b0;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } vertex_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

endpackage

FILE: rtl/ftpf_cell.sv
`timescale 1ns / 1ps
module ftpf_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  ftpf_pkg::vertex_t d_in,
  output ftpf_pkg::vertex_t q
);
  import ftpf_pkg::*;

  vertex_t v_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      v_r <= d_in;
    end
  end

  assign q = v_r;

endmodule

FILE: rtl/ftpf_tri.sv
`timescale 1ns / 1ps
module ftpf_tri (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  ftpf_pkg::vertex_t p,
  input  ftpf_pkg::vertex_t a,
  input  ftpf_pkg::vertex_t b,
  input  ftpf_pkg::vertex_t c,
  output logic             out_valid,
  output logic             flip
);
  import ftpf_pkg::*;

  logic [TRI_LAT-1:0] vld_r;

  logic signed [DIFF_W-1:0] ay_by_r, cx_bx_r, ax_bx_r, cy_by_r, dx_r, dy_r;
  logic signed [DIFF_W-1:0] ey_r, ax_cx_r, ay_cy_r, cy_ay_r;
  logic signed [DIFF_W-1:0] py_ay_r, cx_ax_r, px_ax_r;

  logic signed [PROD_W-1:0] m1_r, m2_r, m3_r, m4_r, m5_r, m6_r, m7_r;
  logic signed [PROD_W-1:0] m8_r, m9_r, m10_r, m11_r, m12_r, m13_r, m14_r;

  logic signed [SUM_W-1:0] area_r, d_r, s_r, t_r, cr_r, dot_r, len_r;

  logic signed [SUM_W:0] st_sum;
  logic                  holds;
  logic                  on_seg;
  logic                  flip_r;

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic [COORD_BITS-1:0] u,
                                                     input logic [COORD_BITS-1:0] v);
    sdiff = $signed({1'b0, u}) - $signed({1'b0, v});
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TRI_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ay_by_r <= sdiff(a.y, b.y);
    cx_bx_r <= sdiff(c.x, b.x);
    ax_bx_r <= sdiff(a.x, b.x);
    cy_by_r <= sdiff(c.y, b.y);
    dx_r    <= sdiff(p.x, c.x);
    dy_r    <= sdiff(p.y, c.y);
    ey_r    <= sdiff(b.y, c.y);
    ax_cx_r <= sdiff(a.x, c.x);
    ay_cy_r <= sdiff(a.y, c.y);
    cy_ay_r <= sdiff(c.y, a.y);
    py_ay_r <= sdiff(p.y, a.y);
    cx_ax_r <= sdiff(c.x, a.x);
    px_ax_r <= sdiff(p.x, a.x);

    m1_r  <= ay_by_r * cx_bx_r;
    m2_r  <= ax_bx_r * cy_by_r;
    m3_r  <= ey_r * ax_cx_r;
    m4_r  <= cx_bx_r * ay_cy_r;
    m5_r  <= ey_r * dx_r;
    m6_r  <= cx_bx_r * dy_r;
    m7_r  <= cy_ay_r * dx_r;
    m8_r  <= ax_cx_r * dy_r;
    m9_r  <= py_ay_r * cx_ax_r;
    m10_r <= px_ax_r * cy_ay_r;
    m11_r <= px_ax_r * cx_ax_r;
    m12_r <= py_ay_r * cy_ay_r;
    m13_r <= cx_ax_r * cx_ax_r;
    m14_r <= cy_ay_r * cy_ay_r;

    area_r <= SUM_W'(m1_r) - SUM_W'(m2_r);
    d_r    <= SUM_W'(m3_r) + SUM_W'(m4_r);
    s_r    <= SUM_W'(m5_r) + SUM_W'(m6_r);
    t_r    <= SUM_W'(m7_r) + SUM_W'(m8_r);
    cr_r   <= SUM_W'(m9_r) - SUM_W'(m10_r);
    dot_r  <= SUM_W'(m11_r) + SUM_W'(m12_r);
    len_r  <= SUM_W'(m13_r) + SUM_W'(m14_r);

    flip_r <= holds && !on_seg;
  end

  always_comb begin
    st_sum = (SUM_W+1)'(s_r) + (SUM_W+1)'(t_r);
    if (area_r == '0) begin
      holds = 1'b0;
    end else if (d_r < 0) begin
      holds = (s_r <= 0) && (t_r <= 0) && (st_sum >= (SUM_W+1)'(d_r));
    end else begin
      holds = (s_r >= 0) && (t_r >= 0) && (st_sum <= (SUM_W+1)'(d_r));
    end
    on_seg = (cr_r == '0) && (dot_r >= 0) && (dot_r <= len_r);
  end

  assign out_valid = vld_r[TRI_LAT-1];
  assign flip      = flip_r;

endmodule

FILE: rtl/fan_triangle_parity_fill.sv
`timescale 1ns / 1ps
// Triangle-fan even-odd fill for one pixel at a time. Start and append items are taken back
// to back and give no result; the vertices live in a chain of cells that shifts a new vertex
// in at its tail. A query whose answer follows from the vertex count, the mode and the
// bounding box goes straight to the output register; any other query rotates the whole
// chain once, one fan triangle per cycle into a four-stage triangle test, whatever the
// number of vertices held. The block takes its next item once a query's result has been
// loaded into the output register.
module fan_triangle_parity_fill (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [11:0] coord_x, [23:12] coord_y, [24] selected_in, [31:25] zero
  input  logic [31:0] in_tdata,
  // [1:0] op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] selected_out, [7:1] zero
  output logic [7:0]  out_tdata,
  // [0] outline_truncated
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ftpf_pkg::*;

  state_t state_r, state_nxt;

  logic [1:0]       mode_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             parity_r, parity_nxt;
  logic             drop_r, drop_nxt;
  logic [COORD_BITS-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [COORD_BITS-1:0] min_x_nxt, max_x_nxt, min_y_nxt, max_y_nxt;
  vertex_t          p_r, prev_r, v0_r, v0_nxt;
  logic             out_valid_r, out_bit_r, out_trunc_r;

  logic [1:0]       op;
  vertex_t          in_v;
  logic             sel_in;
  logic             in_fire;
  logic             do_append;
  logic             shift_en;
  logic             in_box;
  logic             direct;
  logic             direct_bit;
  logic             sweep_init;
  logic             out_load;
  logic             tri_valid;
  logic             tri_out_valid;
  logic             tri_flip;
  logic [CNT_W:0]   pos_sum;
  vertex_t          head;
  vertex_t          tail_in;
  vertex_t          chain_q [MAX_VERTICES];

  assign op      = in_tuser;
  assign in_v.x  = in_tdata[COORD_BITS-1:0];
  assign in_v.y  = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign sel_in  = in_tdata[2*COORD_BITS];
  assign in_fire = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_COMBINE_MODE) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ADD;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_COMBINE_MODE) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  // Chain of vertex cells: appends shift in at the tail, a query rotates the head round.
  assign head     = chain_q[0];
  assign tail_in  = (state_r == ST_RUN) ? head : in_v;
  assign do_append = in_fire && (op == OP_START ||
                                 (op == OP_APPEND && cnt_r < CNT_W'(MAX_VERTICES)));
  assign shift_en = do_append || (state_r == ST_RUN);

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_chain
    if (i == MAX_VERTICES - 1) begin : g_tail
      ftpf_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(tail_in), .q(chain_q[i]));
    end else begin : g_body
      ftpf_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(chain_q[i+1]), .q(chain_q[i]));
    end
  end

  // At sweep step j the head holds vertex j - (MAX_VERTICES - count).
  assign pos_sum   = (CNT_W+1)'(j_r) + (CNT_W+1)'(cnt_r);
  assign tri_valid = (state_r == ST_RUN) && (pos_sum >= (CNT_W+1)'(MAX_VERTICES + 2));

  ftpf_tri u_tri (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tri_valid),
    .p         (p_r),
    .a         (v0_r),
    .b         (prev_r),
    .c         (head),
    .out_valid (tri_out_valid),
    .flip      (tri_flip)
  );

  always_comb begin
    in_box = (in_v.x >= min_x_r) && (in_v.x < max_x_r) &&
             (in_v.y >= min_y_r) && (in_v.y < max_y_r);
    direct     = 1'b1;
    direct_bit = sel_in;
    sweep_init = sel_in;
    if (cnt_r < CNT_W'(3)) begin
      direct = 1'b1;
    end else begin
      case (mode_r)
        MODE_OVERWRITE: begin
          direct     = !in_box;
          direct_bit = 1'b0;
          sweep_init = 1'b0;
        end
        MODE_SUBTRACT: begin
          direct = !sel_in || !in_box;
        end
        default: begin
          direct = sel_in || !in_box;
        end
      endcase
    end
  end

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && op == OP_QUERY) begin
          state_nxt = direct ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (j_r == IDX_W'(MAX_VERTICES - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (j_r == IDX_W'(TRI_LAT - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    j_nxt      = j_r;
    parity_nxt = parity_r;
    cnt_nxt    = cnt_r;
    drop_nxt   = drop_r;
    v0_nxt     = v0_r;
    min_x_nxt  = min_x_r;
    max_x_nxt  = max_x_r;
    min_y_nxt  = min_y_r;
    max_y_nxt  = max_y_r;
    case (state_r)
      ST_IDLE: begin
        j_nxt = '0;
        if (in_fire) begin
          case (op)
            OP_START: begin
              cnt_nxt   = CNT_W'(1);
              drop_nxt  = 1'b0;
              v0_nxt    = in_v;
              min_x_nxt = in_v.x;
              max_x_nxt = in_v.x;
              min_y_nxt = in_v.y;
              max_y_nxt = in_v.y;
            end
            OP_APPEND: begin
              if (do_append) begin
                cnt_nxt = cnt_r + CNT_W'(1);
                if (cnt_r == '0) begin
                  v0_nxt = in_v;
                end
                if (in_v.x < min_x_r) min_x_nxt = in_v.x;
                if (in_v.x > max_x_r) max_x_nxt = in_v.x;
                if (in_v.y < min_y_r) min_y_nxt = in_v.y;
                if (in_v.y > max_y_r) max_y_nxt = in_v.y;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            OP_QUERY: begin
              parity_nxt = direct ? direct_bit : sweep_init;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        j_nxt = (j_r == IDX_W'(MAX_VERTICES - 1)) ? '0 : j_r + IDX_W'(1);
        if (tri_out_valid && tri_flip) parity_nxt = !parity_r;
      end
      ST_DRAIN: begin
        j_nxt = j_r + IDX_W'(1);
        if (tri_out_valid && tri_flip) parity_nxt = !parity_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      min_x_r     <= '1;
      max_x_r     <= '0;
      min_y_r     <= '1;
      max_y_r     <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      min_x_r <= min_x_nxt;
      max_x_r <= max_x_nxt;
      min_y_r <= min_y_nxt;
      max_y_r <= max_y_nxt;
      j_r     <= j_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    parity_r <= parity_nxt;
    v0_r     <= v0_nxt;
    prev_r   <= head;
    if (in_fire) begin
      p_r <= in_v;
    end
    if (out_load) begin
      out_bit_r   <= parity_r;
      out_trunc_r <= drop_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};
  assign out_tuser  = out_trunc_r;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ftpf_pkg::*;

  // Codes the block has no use for.
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [1:0]            op;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  sel;
  } fill_item_t;

  typedef struct {
    logic sel_out;
    logic truncated;
  } mask_answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic        cfg_paddr = 1'b0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  fan_triangle_parity_fill u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's outline and mode register.
  logic [COORD_BITS-1:0] fan_x [MAX_VERTICES];
  logic [COORD_BITS-1:0] fan_y [MAX_VERTICES];
  int                    fan_count = 0;
  logic [COORD_BITS-1:0] lo_x = '1, hi_x = '0, lo_y = '1, hi_y = '0;
  logic                  dropped = 1'b0;
  logic [1:0]            mode = MODE_ADD;

  fill_item_t   send_queue [$];
  fill_item_t   in_flight;
  mask_answer_t awaited [$];
  int           taken_items = 0;
  int           mismatches = 0;
  bit           took = 1'b0;

  logic [1:0] budget_modes [5] = '{MODE_SUBTRACT, MODE_OVERWRITE, MODE_SPARE, MODE_ADD,
                                   MODE_OVERWRITE};

  function automatic bit calm_stretch();
    return taken_items >= 400 && taken_items < 700;
  endfunction

  function automatic bit tri_contains(longint px, longint py, longint ax, longint ay,
                                      longint bx, longint by, longint cx, longint cy);
    longint area, d, s, t;
    area = (ay - by) * (cx - bx) - (ax - bx) * (cy - by);
    if (area == 0) return 1'b0;
    d = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
    s = (by - cy) * (px - cx) + (cx - bx) * (py - cy);
    t = (cy - ay) * (px - cx) + (ax - cx) * (py - cy);
    if (d < 0) return s <= 0 && t <= 0 && (s + t) >= d;
    return s >= 0 && t >= 0 && (s + t) <= d;
  endfunction

  function automatic bit on_spoke(longint px, longint py, longint ax, longint ay,
                                  longint cx, longint cy);
    longint dot;
    if ((py - ay) * (cx - ax) != (px - ax) * (cy - ay)) return 1'b0;
    dot = (px - ax) * (cx - ax) + (py - ay) * (cy - ay);
    return dot >= 0 && dot <= (cx - ax) * (cx - ax) + (cy - ay) * (cy - ay);
  endfunction

  function automatic logic fill_bit(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                    logic b);
    bit in_box;
    in_box = x >= lo_x && x < hi_x && y >= lo_y && y < hi_y;
    if (fan_count < 3) return b;
    if (mode == MODE_OVERWRITE) begin
      if (!in_box) return 1'b0;
      b = 1'b0;
    end else if (mode == MODE_SUBTRACT) begin
      if (!b || !in_box) return b;
    end else begin
      if (b || !in_box) return b;
    end
    for (int k = 0; k + 2 < fan_count; k++)
      if (tri_contains(x, y, fan_x[0], fan_y[0], fan_x[k+1], fan_y[k+1], fan_x[k+2],
                       fan_y[k+2]) &&
          !on_spoke(x, y, fan_x[0], fan_y[0], fan_x[k+2], fan_y[k+2]))
        b = ~b;
    return b;
  endfunction

  task automatic absorb_item(fill_item_t it);
    if (it.op == OP_START) begin
      fan_count = 0;
      lo_x = '1; lo_y = '1; hi_x = '0; hi_y = '0;
      dropped = 1'b0;
    end
    if (it.op == OP_START || it.op == OP_APPEND) begin
      if (fan_count >= MAX_VERTICES) begin
        dropped = 1'b1;
      end else begin
        fan_x[fan_count] = it.x;
        fan_y[fan_count] = it.y;
        fan_count++;
        if (it.x < lo_x) lo_x = it.x;
        if (it.x > hi_x) hi_x = it.x;
        if (it.y < lo_y) lo_y = it.y;
        if (it.y > hi_y) hi_y = it.y;
      end
    end else if (it.op == OP_QUERY) begin
      awaited.push_back('{fill_bit(it.x, it.y, it.sel), dropped});
    end
  endtask

  // Input side: note transfers at the rising edge, present items at the falling edge.
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      took = 1'b1;
      taken_items++;
      absorb_item(in_flight);
    end
  end

  always @(negedge clk) begin
    fill_item_t it;
    if (in_tvalid && !took) begin
      // hold the current item
    end else if (rst_n && send_queue.size() > 0 &&
                 (calm_stretch() || $urandom_range(99) >= 17)) begin
      it = send_queue.pop_front();
      in_flight = it;
      in_tdata  <= {7'd0, it.sel, it.y, it.x};
      in_tuser  <= it.op;
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
    took = 1'b0;
    out_tready <= calm_stretch() || $urandom_range(99) >= 17;
  end

  always @(posedge clk) begin
    mask_answer_t want;
    if (out_tvalid && out_tready) begin
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %b/%b", out_tdata[0],
                                       out_tuser);
      end else begin
        want = awaited.pop_front();
        if (out_tdata !== {7'd0, want.sel_out} || out_tuser !== want.truncated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected sel %b trunc %b, got tdata %h trunc %b",
                     want.sel_out, want.truncated, out_tdata, out_tuser);
        end
      end
    end
  end

  task automatic put(logic [1:0] op, int x, int y, logic sel);
    send_queue.push_back('{op, x[COORD_BITS-1:0], y[COORD_BITS-1:0], sel});
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (send_queue.size() > 0 || in_tvalid || awaited.size() > 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= REG_COMBINE_MODE;
    cfg_pwdata <= {$urandom_range(1) ? 30'h3fff_ffff : 30'd0, m};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    mode = m;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // One outline with random content followed by queries, sometimes interleaved with noise.
  task automatic random_outline(bit huge);
    int n, cx, cy, span, mnx, mxx, mny, mxy, vx, vy, q;
    n = huge ? $urandom_range(250, 262) :
        ($urandom_range(9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 9));
    span = $urandom_range(3) == 0 ? 4095 : $urandom_range(2, 60);
    cx = $urandom_range(4095); cy = $urandom_range(4095);
    mnx = 4095; mny = 4095; mxx = 0; mxy = 0;
    for (int i = 0; i < n; i++) begin
      vx = span == 4095 ? $urandom_range(4095) : (cx + $urandom_range(span)) % 4096;
      vy = span == 4095 ? $urandom_range(4095) : (cy + $urandom_range(span)) % 4096;
      if ($urandom_range(15) == 0) vx = $urandom_range(1) ? 0 : 4095;
      if (vx < mnx) mnx = vx;
      if (vx > mxx) mxx = vx;
      if (vy < mny) mny = vy;
      if (vy > mxy) mxy = vy;
      put(i == 0 ? OP_START : OP_APPEND, vx, vy, 1'($urandom_range(1)));
      if ($urandom_range(30) == 0)
        put(OP_IGNORED, $urandom_range(4095), $urandom_range(4095), 1'b1);
    end
    q = huge ? 6 : $urandom_range(2, 8);
    for (int i = 0; i < q; i++) begin
      if ($urandom_range(7) == 0)
        put(OP_QUERY, $urandom_range(4095), $urandom_range(4095), 1'($urandom_range(1)));
      else
        put(OP_QUERY, $urandom_range(mnx, mxx), $urandom_range(mny, mxy),
            1'($urandom_range(1)));
    end
  endtask

  initial begin
    int budget;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty and short outlines, the unused op code, triangle edges and corners,
    // the shared spoke, the open side of the box and a degenerate triangle.
    put(OP_QUERY, 5, 5, 1'b0);
    put(OP_IGNORED, 4095, 4095, 1'b1);
    put(OP_START, 0, 0, 1'b0);
    put(OP_APPEND, 4095, 0, 1'b0);
    put(OP_QUERY, 10, 10, 1'b1);
    put(OP_APPEND, 0, 4095, 1'b1);
    put(OP_QUERY, 0, 0, 1'b0);
    put(OP_QUERY, 100, 100, 1'b0);
    put(OP_QUERY, 100, 0, 1'b0);
    put(OP_QUERY, 0, 100, 1'b0);
    put(OP_QUERY, 4095, 0, 1'b0);
    put(OP_QUERY, 2047, 2048, 1'b0);
    put(OP_QUERY, 3000, 3000, 1'b0);
    put(OP_QUERY, 100, 100, 1'b1);
    put(OP_APPEND, 0, 2000, 1'b0);
    put(OP_QUERY, 0, 50, 1'b0);
    put(OP_QUERY, 4094, 4094, 1'b1);
    put(OP_QUERY, 1, 1, 1'b0);
    wait_quiet();

    foreach (budget_modes[i]) begin
      write_mode(budget_modes[i]);
      budget = 300;
      if (i == 0 || i == 3) random_outline(1'b1);
      while (send_queue.size() < budget) random_outline(1'b0);
      // Let everything drain before the next mode.
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
